// ===== hdl/fvg_pkg.sv =====
// shared types, constants and size-table lookup for the fat volume geometry block
package fvg_pkg;

    localparam int FAT_COPIES_DEF = 2;
    localparam int DIV_W = 36;
    localparam int SB_W = 16;

    localparam logic [1:0] TYPE_AUTO  = 2'd0;
    localparam logic [1:0] TYPE_FAT12 = 2'd1;
    localparam logic [1:0] TYPE_FAT16 = 2'd2;
    localparam logic [1:0] TYPE_FAT32 = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_TOO_SMALL = 2'd2;

    localparam logic [15:0] SB_STD      = 16'd512;
    localparam logic [31:0] FAT12_MAX   = 32'd4084;
    localparam logic [31:0] FAT16_MIN   = 32'd4085;
    localparam logic [31:0] FAT16_MAX   = 32'd65524;
    localparam logic [31:0] FAT32_MIN   = 32'd65525;
    localparam logic [16:0] ROOT_BYTES  = 17'd16384;

    typedef struct packed {
        logic [1:0]  requested_type;
        logic [31:0] volume_sectors;
        logic [7:0]  requested_cluster_size;
    } t_fvg_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  chosen_type;
        logic [7:0]  cluster_size;
        logic [31:0] cluster_count;
        logic [31:0] fat_size;
        logic [5:0]  reserved_count;
        logic [14:0] root_dir_size;
        logic [15:0] small_total;
        logic [31:0] large_total;
        logic [31:0] free_clusters;
        logic [3:0]  root_fat_sector;
        logic [13:0] root_fat_word;
    } t_fvg_out;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [SB_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [SB_W-1:0]  rem;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_RDS_GO, S_RDS_WAIT, S_RANGE, S_HI_GO, S_HI_WAIT,
        S_LOOP, S_FAT_GO, S_FAT_WAIT, S_MUL, S_CMP, S_LIMIT, S_OFF_GO,
        S_OFF_WAIT, S_DONE
    } t_state;

    function automatic logic [7:0] lookup(input logic [1:0] fat_type,
                                          input logic [31:0] total,
                                          input logic forced);
        logic [7:0] spc;
        spc = 8'd0;
        if (fat_type == TYPE_FAT12) begin
            if (total <= 32'd8200) spc = 8'd2;
            else if (total <= 32'd16368) spc = 8'd4;
            else if (total <= 32'd32704) spc = 8'd8;
            else if (!forced) spc = 8'd0;
            else if (total <= 32'd65376) spc = 8'd16;
            else if (total <= 32'd130720) spc = 8'd32;
            else if (total <= 32'd261408) spc = 8'd64;
            else spc = 8'd0;
        end else if (fat_type == TYPE_FAT16) begin
            if (total <= 32'd8400) spc = 8'd0;
            else if (total <= 32'd32680) spc = 8'd2;
            else if (total <= 32'd262144) spc = 8'd4;
            else if (total <= 32'd524288) spc = 8'd8;
            else if (total <= 32'd1048576) spc = 8'd16;
            else if (!forced) spc = 8'd0;
            else if (total <= 32'd2097152) spc = 8'd32;
            else if (total <= 32'd4194304) spc = 8'd64;
            else spc = 8'd0;
        end else if (fat_type == TYPE_FAT32) begin
            if (total <= 32'd66600) spc = 8'd0;
            else if (total <= 32'd532480) spc = 8'd1;
            else if (total <= 32'd16777216) spc = 8'd8;
            else if (total <= 32'd33554432) spc = 8'd16;
            else if (total <= 32'd67108864) spc = 8'd32;
            else spc = 8'd64;
        end
        return spc;
    endfunction

endpackage

// ===== hdl/fvg_div.sv =====
// shared restoring divider, one quotient bit per cycle
module fvg_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fvg_pkg::t_div_req i_req,
    output fvg_pkg::t_div_rsp o_rsp
);
    localparam int CNT_W = $clog2(fvg_pkg::DIV_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(fvg_pkg::DIV_W - 1);

    logic                       r_busy;
    logic                       r_done;
    logic [CNT_W-1:0]           r_cnt;
    logic [fvg_pkg::DIV_W-1:0]  r_quo;
    logic [fvg_pkg::SB_W-1:0]   r_rem;
    logic [fvg_pkg::SB_W-1:0]   r_dvs;
    logic [fvg_pkg::SB_W:0]     trial;
    logic                       qbit;
    logic [fvg_pkg::SB_W:0]     diff;

    always_comb begin
        trial = {r_rem, r_quo[fvg_pkg::DIV_W-1]};
        diff  = trial - {1'b0, r_dvs};
        qbit  = (trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[fvg_pkg::DIV_W-2:0], qbit};
            r_rem <= qbit ? diff[fvg_pkg::SB_W-1:0] : trial[fvg_pkg::SB_W-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

// ===== hdl/fat_volume_geometry_core.sv =====
// fat volume geometry: sequencer around one shared divider
// Usage: present a word on i_in_data with i_in_valid; it is taken at an edge where
// o_in_stall is low. o_in_stall stays high while a word is being worked on, so one
// word is processed at a time. The result word appears on o_out_data with
// o_out_valid and is held until an edge with i_out_stall low. A finished result
// sits in the output register, so the sequencer returns to idle while it waits.
// A word rejected on its parameters goes straight from the check to the result.
// FAT32 skips the root-directory division; every other division and each step of
// the cluster-count search run on the 36-bit divider, which yields one quotient bit
// per cycle.
// Sector size is to be written through i_cfg_wr_en / i_cfg_wr_data only while idle;
// the block does not enforce this. Reset (synchronous, active low) returns to idle,
// empties the output register and sets the sector size to 512.
module fat_volume_geometry_core #(
    parameter int FAT_COPIES = fvg_pkg::FAT_COPIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  fvg_pkg::t_fvg_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output fvg_pkg::t_fvg_out o_out_data,
    input  logic              i_cfg_wr_en,
    input  logic [15:0]       i_cfg_wr_data
);
    fvg_pkg::t_state   r_state, n_state;
    fvg_pkg::t_div_req div_req;
    fvg_pkg::t_div_rsp div_rsp;
    fvg_pkg::t_fvg_in  r_in;
    fvg_pkg::t_fvg_out r_out, n_out;

    logic        r_out_valid;
    logic [15:0] r_sector_bytes;
    logic [1:0]  r_type;
    logic [7:0]  r_spc;
    logic [1:0]  r_status;
    logic [5:0]  r_rsv;
    logic [14:0] r_rds;
    logic [31:0] r_lo, r_hi, r_mid;
    logic [35:0] r_fsz;
    logic [39:0] r_prod;
    logic        r_last;
    logic [3:0]  r_off_sec;
    logic [13:0] r_off_word;

    logic        accept, out_free;
    logic        chk_err;
    logic [1:0]  chk_type;
    logic [7:0]  chk_spc;
    logic        range_bad, loop_more, lim_bad, fit_ok;
    logic [31:0] mid_calc;
    logic [32:0] span;
    logic [32:0] nclu;
    logic [34:0] fat_bytes;
    logic [40:0] fit_sum;
    logic [3:0]  off;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // parameter checks and table lookup
    always_comb begin
        chk_err  = 1'b0;
        chk_type = r_in.requested_type;
        chk_spc  = r_in.requested_cluster_size;
        if (chk_type == fvg_pkg::TYPE_AUTO) begin
            if (chk_spc != 8'd0 || r_sector_bytes != fvg_pkg::SB_STD) begin
                chk_err = 1'b1;
            end else begin
                chk_spc = fvg_pkg::lookup(fvg_pkg::TYPE_FAT12, r_in.volume_sectors, 1'b0);
                if (chk_spc != 8'd0) begin
                    chk_type = fvg_pkg::TYPE_FAT12;
                end else begin
                    chk_spc = fvg_pkg::lookup(fvg_pkg::TYPE_FAT16, r_in.volume_sectors, 1'b0);
                    if (chk_spc != 8'd0) begin
                        chk_type = fvg_pkg::TYPE_FAT16;
                    end else begin
                        chk_spc = fvg_pkg::lookup(fvg_pkg::TYPE_FAT32,
                                                  r_in.volume_sectors, 1'b0);
                        if (chk_spc != 8'd0) chk_type = fvg_pkg::TYPE_FAT32;
                    end
                end
                if (chk_type == fvg_pkg::TYPE_AUTO) chk_err = 1'b1;
            end
        end
        if (!chk_err && chk_spc == 8'd0) begin
            if (r_sector_bytes != fvg_pkg::SB_STD) begin
                chk_err = 1'b1;
            end else begin
                chk_spc = fvg_pkg::lookup(chk_type, r_in.volume_sectors, 1'b1);
                if (chk_spc == 8'd0) chk_err = 1'b1;
            end
        end
        if (!chk_err && r_sector_bytes == 16'd0) chk_err = 1'b1;
    end

    always_comb begin
        range_bad = (33'(r_rsv) + 33'(r_rds)) > 33'(r_in.volume_sectors);
        loop_more = r_lo < r_hi;
        span      = 33'(r_hi) - 33'(r_lo) + 33'd1;
        mid_calc  = r_lo + span[32:1];
        nclu      = 33'(r_mid) + 33'd2;
        unique case (r_type)
            fvg_pkg::TYPE_FAT12: fat_bytes = 35'(nclu) + 35'(nclu[32:1]);
            fvg_pkg::TYPE_FAT16: fat_bytes = {1'b0, nclu, 1'b0};
            default:             fat_bytes = {nclu, 2'b00};
        endcase
        fit_sum = 41'(r_rsv) + 41'(r_fsz) * 41'(FAT_COPIES) + 41'(r_prod);
        fit_ok  = fit_sum <= 41'(r_in.volume_sectors);
        unique case (r_type)
            fvg_pkg::TYPE_FAT12: lim_bad = r_lo > fvg_pkg::FAT12_MAX;
            fvg_pkg::TYPE_FAT16: lim_bad = r_lo > fvg_pkg::FAT16_MAX ||
                                           r_lo < fvg_pkg::FAT16_MIN;
            default:             lim_bad = r_lo < fvg_pkg::FAT32_MIN;
        endcase
        unique case (r_type)
            fvg_pkg::TYPE_FAT12: off = 4'd4;
            fvg_pkg::TYPE_FAT16: off = 4'd6;
            default:             off = 4'd12;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fvg_pkg::S_IDLE:     if (accept) n_state = fvg_pkg::S_CHECK;
            fvg_pkg::S_CHECK: begin
                if (chk_err) n_state = fvg_pkg::S_DONE;
                else if (chk_type == fvg_pkg::TYPE_FAT32) n_state = fvg_pkg::S_RANGE;
                else n_state = fvg_pkg::S_RDS_GO;
            end
            fvg_pkg::S_RDS_GO:   n_state = fvg_pkg::S_RDS_WAIT;
            fvg_pkg::S_RDS_WAIT: if (div_rsp.done) n_state = fvg_pkg::S_RANGE;
            fvg_pkg::S_RANGE:    n_state = range_bad ? fvg_pkg::S_DONE : fvg_pkg::S_HI_GO;
            fvg_pkg::S_HI_GO:    n_state = fvg_pkg::S_HI_WAIT;
            fvg_pkg::S_HI_WAIT:  if (div_rsp.done) n_state = fvg_pkg::S_LOOP;
            fvg_pkg::S_LOOP: begin
                if (!loop_more && r_lo == 32'd0) n_state = fvg_pkg::S_DONE;
                else n_state = fvg_pkg::S_FAT_GO;
            end
            fvg_pkg::S_FAT_GO:   n_state = fvg_pkg::S_FAT_WAIT;
            fvg_pkg::S_FAT_WAIT: begin
                if (div_rsp.done) n_state = r_last ? fvg_pkg::S_LIMIT : fvg_pkg::S_MUL;
            end
            fvg_pkg::S_MUL:      n_state = fvg_pkg::S_CMP;
            fvg_pkg::S_CMP:      n_state = fvg_pkg::S_LOOP;
            fvg_pkg::S_LIMIT:    n_state = lim_bad ? fvg_pkg::S_DONE : fvg_pkg::S_OFF_GO;
            fvg_pkg::S_OFF_GO:   n_state = fvg_pkg::S_OFF_WAIT;
            fvg_pkg::S_OFF_WAIT: if (div_rsp.done) n_state = fvg_pkg::S_DONE;
            fvg_pkg::S_DONE:     if (out_free) n_state = fvg_pkg::S_IDLE;
            default:             n_state = fvg_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_stall       = (r_state != fvg_pkg::S_IDLE);
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = r_sector_bytes;
        unique case (r_state)
            fvg_pkg::S_RDS_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = 36'(fvg_pkg::ROOT_BYTES + 17'(r_sector_bytes) - 17'd1);
            end
            fvg_pkg::S_HI_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = 36'(r_in.volume_sectors - 32'(r_rsv) - 32'(r_rds));
                div_req.divisor  = 16'(r_spc);
            end
            fvg_pkg::S_FAT_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = 36'(fat_bytes) + 36'(r_sector_bytes) - 36'd1;
            end
            fvg_pkg::S_OFF_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = 36'(off);
            end
            default: ;
        endcase
    end

    always_comb begin
        n_out        = '0;
        n_out.status = r_status;
        if (r_status == fvg_pkg::ST_OK) begin
            n_out.chosen_type     = r_type;
            n_out.cluster_size    = r_spc;
            n_out.cluster_count   = r_lo;
            n_out.fat_size        = r_fsz[31:0];
            n_out.reserved_count  = r_rsv;
            n_out.root_dir_size   = r_rds;
            if (r_type == fvg_pkg::TYPE_FAT32 || r_in.volume_sectors > 32'hFFFF) begin
                n_out.large_total = r_in.volume_sectors;
            end else begin
                n_out.small_total = r_in.volume_sectors[15:0];
            end
            n_out.free_clusters   = r_lo - 32'd1;
            n_out.root_fat_sector = r_off_sec;
            n_out.root_fat_word   = r_off_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= fvg_pkg::S_IDLE;
            r_out_valid    <= 1'b0;
            r_sector_bytes <= fvg_pkg::SB_STD;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) r_sector_bytes <= i_cfg_wr_data;
            if (r_state == fvg_pkg::S_DONE && out_free) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            fvg_pkg::S_IDLE: if (accept) r_in <= i_in_data;
            fvg_pkg::S_CHECK: begin
                r_type   <= chk_type;
                r_spc    <= chk_spc;
                r_status <= chk_err ? fvg_pkg::ST_INVALID : fvg_pkg::ST_OK;
                r_rsv    <= (chk_type == fvg_pkg::TYPE_FAT32) ? 6'd32 : 6'd1;
                r_rds    <= '0;
                r_last   <= 1'b0;
            end
            fvg_pkg::S_RDS_WAIT: if (div_rsp.done) r_rds <= div_rsp.quot[14:0];
            fvg_pkg::S_RANGE: if (range_bad) r_status <= fvg_pkg::ST_TOO_SMALL;
            fvg_pkg::S_HI_WAIT: begin
                if (div_rsp.done) begin
                    r_hi <= div_rsp.quot[31:0];
                    r_lo <= '0;
                end
            end
            fvg_pkg::S_LOOP: begin
                if (loop_more) begin
                    r_mid <= mid_calc;
                end else if (r_lo == 32'd0) begin
                    r_status <= fvg_pkg::ST_TOO_SMALL;
                end else begin
                    r_mid  <= r_lo;
                    r_last <= 1'b1;
                end
            end
            fvg_pkg::S_FAT_WAIT: if (div_rsp.done) r_fsz <= div_rsp.quot;
            fvg_pkg::S_MUL: r_prod <= 40'(r_mid) * 40'(r_spc);
            fvg_pkg::S_CMP: begin
                if (fit_ok) r_lo <= r_mid;
                else r_hi <= r_mid - 32'd1;
            end
            fvg_pkg::S_LIMIT: if (lim_bad) r_status <= fvg_pkg::ST_INVALID;
            fvg_pkg::S_OFF_WAIT: begin
                if (div_rsp.done) begin
                    r_off_sec  <= div_rsp.quot[3:0];
                    r_off_word <= div_rsp.rem[15:2];
                end
            end
            fvg_pkg::S_DONE: if (out_free) r_out <= n_out;
            default: ;
        endcase
    end

    fvg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status != fvg_pkg::ST_OK |->
            r_out.chosen_type == 2'd0 && r_out.cluster_count == 32'd0)
        else $error("error word carries geometry");

    a_ok_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status == fvg_pkg::ST_OK |->
            r_out.cluster_count != 32'd0 &&
            r_out.free_clusters == r_out.cluster_count - 32'd1)
        else $error("bad cluster count in ok word");

    a_mid_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == fvg_pkg::S_CMP |-> r_mid > r_lo && r_mid <= r_hi)
        else $error("search midpoint outside window");

    a_fat32_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status == fvg_pkg::ST_OK &&
            r_out.chosen_type == fvg_pkg::TYPE_FAT32 |-> r_out.small_total == 16'd0)
        else $error("fat32 word uses small total");

endmodule
